// ===== rtl/fcfe_pkg.sv =====
// Package for the four-corner frame estimator.
// Holds shared widths, row codes, defaults and the rounding helper.
// No dependencies.
package fcfe_pkg;

	localparam int FCFE_WINDOW = 128;

	localparam int POS_W  = 32;
	localparam int NV_W   = 35;
	localparam int MAG_W  = NV_W - 1;
	localparam int UNIT_W = 18;
	localparam int DIV_W  = 48;
	localparam int DEN_W  = 32;
	localparam int MA_W   = 31;
	localparam int MB_W   = NV_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 68;
	localparam int ONE_Q16 = 65536;

	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [NV_W-1:0]   nvec_t;
	typedef logic signed [POS_W-1:0]  pos_t;

	// round to nearest, half away from zero, after a right shift by s
	function automatic logic signed [ACC_W-1:0] rnd_shift(
		input logic signed [ACC_W-1:0] v,
		input int unsigned s
	);
		logic [ACC_W-1:0] mag;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		mag = (mag + (ACC_W'(1) << (s - 1))) >> s;
		return v[ACC_W-1] ? -signed'(mag) : signed'(mag);
	endfunction

endpackage

// ===== rtl/four_corner_frame_estimator.sv =====
// Four-corner frame estimator: windowed corner averages, frame basis and offsets.
// Depends on fcfe_pkg for widths, row codes and rounding.
//
// Usage: the slave channel takes one word per corner sample: s_tuser holds the
// corner index, s_tdata holds pos_x, pos_y, pos_z (signed Q16.16). Each sample
// enters its corner's ring window of WINDOW entries and the running sums.
// Once all four corners hold a sample, each word yields three master words,
// rows x, y, z in order, the third with m_tlast high.
// Processing time from accept to the last row is set by the bit-serial
// divider (one quotient each for 12 averages and 9 unit-vector components),
// the shift-and-subtract square root (three times, skipped for a zero
// vector), the normalise scaling and the shared multiplier. A word that
// leaves a corner empty returns the sequencer to idle after the window
// update and the corner check. One word at a time: s_tready is high only
// while the sequencer is idle.
// Reset clears sums, counts and write slots; no clearing pass is needed.
// A stalled receiver holds the current row in the output register and the
// sequencer waits before loading the next row; a new input word may be taken
// while the last row still waits.
module four_corner_frame_estimator
	import fcfe_pkg::*;
#(
	parameter int WINDOW = FCFE_WINDOW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
	input  logic [1:0]  s_tuser,   // corner[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // basis_x[17:0], basis_y[35:18], basis_z[53:36],
	                               // offset[85:54], zero[87:86]
	output logic [2:0]  m_tuser,   // row[1:0], degenerate[2]
	output logic        m_tlast    // last_row
);

	localparam int CW    = $clog2(WINDOW + 1);
	localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUMW  = POS_W + CW;
	localparam int AW    = 2 + SW + 2;
	localparam int DEPTH = 1 << AW;
	localparam int DCW   = $clog2(DIV_W);

	localparam logic [MAG_W-1:0] LO_LIM = MAG_W'(1) << 29;
	localparam logic [MAG_W-1:0] HI_LIM = MAG_W'(1) << 30;
	localparam logic signed [ACC_W-1:0] UNIT_MAX = ACC_W'(ONE_Q16);
	localparam logic signed [ACC_W-1:0] UNIT_MIN = -UNIT_MAX;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_WR, ST_UPD, ST_CHK, ST_AVG_LD, ST_DIV, ST_AVG_ST,
		ST_SUMS, ST_NABS, ST_NSCALE, ST_NSQ_M, ST_NSQ_A, ST_NSQRT, ST_NDIV_LD,
		ST_NDIV_ST, ST_NDONE, ST_CR_M1, ST_CR_M2, ST_CR_F, ST_CR_END,
		ST_DOT_M, ST_DOT_A, ST_DOT_F, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {NS_X, NS_Y, NS_Z} nsel_t;

	state_t state_q;
	nsel_t  nsel_q;

	logic [1:0]  corner_q;
	pos_t        pos_q [3];
	logic [1:0]  idx_q;
	logic [1:0]  ck_q;

	logic [POS_W-1:0] mem [DEPTH];
	logic [POS_W-1:0] mem_rd_q;
	logic [AW-1:0]    mem_addr;
	logic             mem_we;

	logic signed [SUMW-1:0] sum_q [4][3];
	logic [CW-1:0]          cnt_q [4];
	logic [SW-1:0]          slot_q [4];

	logic [DIV_W-1:0] dnum_q;
	logic [DEN_W-1:0] dden_q;
	logic [DEN_W:0]   drem_q;
	logic [DCW-1:0]   dcnt_q;
	logic             dret_q;
	logic             dsgn_q;

	pos_t  avg_q [4][3];
	nvec_t t4_q [3];
	nvec_t yv_q [3];
	nvec_t nv_q [3];

	logic [MAG_W-1:0] mag_q [3];
	logic             nsgn_q [3];

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [63:0] sqv_q, sres_q, sbit_q;

	unit_t nout_q [3];
	unit_t xn_q [3], yn_q [3], zn_q [3], ny_q [3];
	unit_t cross_q [3];
	logic  csel_q;
	logic [1:0] rowk_q;
	logic  deg_q;
	logic signed [POS_W-1:0] off_q;

	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tlast_q;

	// combinational helpers
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	unit_t pv [3], qv [3], rv [3];
	logic [1:0] i1, i2;
	logic [MAG_W-1:0] mx;
	logic [MAG_W-1:0] nv_mag [3];
	logic nv_zero;
	nvec_t t4_c [3], xv_c [3], yv_c [3];
	logic [DEN_W:0] rem_next;
	logic           div_ge;
	logic [SUMW-1:0] sum_abs;
	logic signed [SUMW-1:0] sum_new;
	logic full;
	logic signed [ACC_W-1:0] cr_r, off_r;
	unit_t cr_c;
	logic signed [POS_W-1:0] off_c;
	logic [DIV_W-1:0] q_clamp;
	logic [63:0] sq_t;
	logic sq_ge;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	assign mem_addr = {corner_q, slot_q[corner_q], idx_q};
	assign mem_we   = (state_q == ST_WR);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pos_q[idx_q];
		end
		mem_rd_q <= mem[mem_addr];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pv[i] = csel_q ? zn_q[i] : xn_q[i];
			qv[i] = csel_q ? xn_q[i] : yn_q[i];
		end
		case (rowk_q)
			ROW_X:   rv = xn_q;
			ROW_Y:   rv = ny_q;
			default: rv = zn_q;
		endcase
		case (idx_q)
			2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
			2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
			default: begin i1 = 2'd0; i2 = 2'd1; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_NSQ_M: begin
				mul_a = {1'b0, mag_q[idx_q][29:0]};
				mul_b = {{(MB_W-30){1'b0}}, mag_q[idx_q][29:0]};
			end
			ST_CR_M1: begin
				mul_a = MA_W'(pv[i1]);
				mul_b = MB_W'(qv[i2]);
			end
			ST_CR_M2: begin
				mul_a = MA_W'(pv[i2]);
				mul_b = MB_W'(qv[i1]);
			end
			ST_DOT_M: begin
				mul_a = MA_W'(rv[idx_q]);
				mul_b = t4_q[idx_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		nv_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			nv_mag[i] = nv_q[i][NV_W-1] ? MAG_W'(-nv_q[i]) : MAG_W'(nv_q[i]);
			if (nv_q[i] != '0) nv_zero = 1'b0;
		end
		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
		for (int i = 0; i < 3; i++) begin
			t4_c[i] = NV_W'(avg_q[0][i]) + NV_W'(avg_q[1][i]) + NV_W'(avg_q[2][i])
				+ NV_W'(avg_q[3][i]);
			xv_c[i] = (NV_W'(avg_q[2][i]) - NV_W'(avg_q[0][i]))
				+ (NV_W'(avg_q[3][i]) - NV_W'(avg_q[1][i]));
			yv_c[i] = (NV_W'(avg_q[1][i]) - NV_W'(avg_q[0][i]))
				+ (NV_W'(avg_q[3][i]) - NV_W'(avg_q[2][i]));
		end
	end

	always_comb begin
		rem_next = {drem_q[DEN_W-1:0], dnum_q[DIV_W-1]};
		div_ge   = (rem_next >= {1'b0, dden_q});
		sum_abs  = sum_q[ck_q][idx_q][SUMW-1] ? SUMW'(-sum_q[ck_q][idx_q])
			: SUMW'(sum_q[ck_q][idx_q]);
		full     = (cnt_q[corner_q] == CW'(WINDOW));
		sum_new  = sum_q[corner_q][idx_q] + SUMW'(pos_q[idx_q])
			- (full ? SUMW'(signed'(mem_rd_q)) : SUMW'(0));
		cr_r = rnd_shift(acc_q - ACC_W'(prod_q), 16);
		if (cr_r > UNIT_MAX)      cr_c = UNIT_W'(UNIT_MAX);
		else if (cr_r < UNIT_MIN) cr_c = UNIT_W'(UNIT_MIN);
		else                      cr_c = UNIT_W'(cr_r);
		off_r = rnd_shift(-acc_q, 18);
		if (off_r[ACC_W-1:POS_W-1] == '0 || off_r[ACC_W-1:POS_W-1] == '1) begin
			off_c = POS_W'(off_r);
		end else begin
			off_c = off_r[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		q_clamp = (dnum_q > DIV_W'(ONE_Q16)) ? DIV_W'(ONE_Q16) : dnum_q;
		sq_t  = sres_q + sbit_q;
		sq_ge = (sqv_q >= sq_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nsel_q     <= NS_X;
			corner_q   <= '0;
			idx_q      <= '0;
			ck_q       <= '0;
			dnum_q     <= '0;
			dden_q     <= '0;
			drem_q     <= '0;
			dcnt_q     <= '0;
			dret_q     <= 1'b0;
			dsgn_q     <= 1'b0;
			prod_q     <= '0;
			acc_q      <= '0;
			sqv_q      <= '0;
			sres_q     <= '0;
			sbit_q     <= '0;
			csel_q     <= 1'b0;
			rowk_q     <= ROW_X;
			deg_q      <= 1'b0;
			off_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k]  <= '0;
				slot_q[k] <= '0;
				for (int i = 0; i < 3; i++) begin
					sum_q[k][i] <= '0;
					avg_q[k][i] <= '0;
				end
			end
			for (int i = 0; i < 3; i++) begin
				pos_q[i]   <= '0;
				t4_q[i]    <= '0;
				yv_q[i]    <= '0;
				nv_q[i]    <= '0;
				mag_q[i]   <= '0;
				nsgn_q[i]  <= 1'b0;
				nout_q[i]  <= '0;
				xn_q[i]    <= '0;
				yn_q[i]    <= '0;
				zn_q[i]    <= '0;
				ny_q[i]    <= '0;
				cross_q[i] <= '0;
			end
		end else begin
			prod_q <= mul_a * mul_b;
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						corner_q <= s_tuser;
						pos_q[0] <= s_tdata[31:0];
						pos_q[1] <= s_tdata[63:32];
						pos_q[2] <= s_tdata[95:64];
						idx_q    <= '0;
						deg_q    <= 1'b0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					sum_q[corner_q][idx_q] <= sum_new;
					if (idx_q == 2'd2) begin
						state_q <= ST_UPD;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_RD;
					end
				end
				ST_UPD: begin
					slot_q[corner_q] <= (slot_q[corner_q] == SW'(WINDOW - 1)) ? '0
						: slot_q[corner_q] + SW'(1);
					if (!full) cnt_q[corner_q] <= cnt_q[corner_q] + CW'(1);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					ck_q  <= '0;
					idx_q <= '0;
					if (cnt_q[0] != '0 && cnt_q[1] != '0 && cnt_q[2] != '0
						&& cnt_q[3] != '0) begin
						state_q <= ST_AVG_LD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_AVG_LD: begin
					dnum_q  <= DIV_W'(sum_abs);
					dden_q  <= DEN_W'(cnt_q[ck_q]);
					dsgn_q  <= sum_q[ck_q][idx_q][SUMW-1];
					drem_q  <= '0;
					dcnt_q  <= '0;
					dret_q  <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					drem_q <= div_ge ? rem_next - {1'b0, dden_q} : rem_next;
					dnum_q <= {dnum_q[DIV_W-2:0], div_ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(DIV_W - 1)) begin
						state_q <= dret_q ? ST_NDIV_ST : ST_AVG_ST;
					end
				end
				ST_AVG_ST: begin
					avg_q[ck_q][idx_q] <= dsgn_q ? -POS_W'(dnum_q) : POS_W'(dnum_q);
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						ck_q  <= ck_q + 2'd1;
						state_q <= (ck_q == 2'd3) ? ST_SUMS : ST_AVG_LD;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_AVG_LD;
					end
				end
				ST_SUMS: begin
					t4_q    <= t4_c;
					yv_q    <= yv_c;
					nv_q    <= xv_c;
					nsel_q  <= NS_X;
					state_q <= ST_NABS;
				end
				ST_NABS: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i]  <= nv_mag[i];
						nsgn_q[i] <= nv_q[i][NV_W-1];
					end
					if (nv_zero) begin
						for (int i = 0; i < 3; i++) nout_q[i] <= '0;
						deg_q   <= 1'b1;
						state_q <= ST_NDONE;
					end else begin
						state_q <= ST_NSCALE;
					end
				end
				ST_NSCALE: begin
					if (mx < LO_LIM) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else if (mx >= HI_LIM) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_NSQ_M;
					end
				end
				ST_NSQ_M: state_q <= ST_NSQ_A;
				ST_NSQ_A: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (idx_q == 2'd2) begin
						sqv_q   <= 64'(acc_q + ACC_W'(prod_q));
						sres_q  <= '0;
						sbit_q  <= 64'(1) << 62;
						state_q <= ST_NSQRT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_NSQ_M;
					end
				end
				ST_NSQRT: begin
					if (sq_ge) begin
						sqv_q  <= sqv_q - sq_t;
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					if (sbit_q == 64'd1) begin
						idx_q   <= '0;
						state_q <= ST_NDIV_LD;
					end
				end
				ST_NDIV_LD: begin
					dnum_q  <= DIV_W'({mag_q[idx_q][29:0], 16'b0}) + DIV_W'(sres_q >> 1);
					dden_q  <= sres_q[DEN_W-1:0];
					drem_q  <= '0;
					dcnt_q  <= '0;
					dret_q  <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_NDIV_ST: begin
					nout_q[idx_q] <= nsgn_q[idx_q] ? -UNIT_W'(q_clamp) : UNIT_W'(q_clamp);
					if (idx_q == 2'd2) begin
						state_q <= ST_NDONE;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_NDIV_LD;
					end
				end
				ST_NDONE: begin
					idx_q <= '0;
					case (nsel_q)
						NS_X: begin
							xn_q    <= nout_q;
							nv_q    <= yv_q;
							nsel_q  <= NS_Y;
							state_q <= ST_NABS;
						end
						NS_Y: begin
							yn_q    <= nout_q;
							csel_q  <= 1'b0;
							state_q <= ST_CR_M1;
						end
						default: begin
							zn_q    <= nout_q;
							csel_q  <= 1'b1;
							state_q <= ST_CR_M1;
						end
					endcase
				end
				ST_CR_M1: state_q <= ST_CR_M2;
				ST_CR_M2: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= ST_CR_F;
				end
				ST_CR_F: begin
					cross_q[idx_q] <= cr_c;
					if (idx_q == 2'd2) begin
						state_q <= ST_CR_END;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_CR_M1;
					end
				end
				ST_CR_END: begin
					idx_q <= '0;
					if (!csel_q) begin
						for (int i = 0; i < 3; i++) nv_q[i] <= NV_W'(cross_q[i]);
						nsel_q  <= NS_Z;
						state_q <= ST_NABS;
					end else begin
						ny_q    <= cross_q;
						rowk_q  <= ROW_X;
						acc_q   <= '0;
						state_q <= ST_DOT_M;
					end
				end
				ST_DOT_M: state_q <= ST_DOT_A;
				ST_DOT_A: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (idx_q == 2'd2) begin
						state_q <= ST_DOT_F;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_DOT_M;
					end
				end
				ST_DOT_F: begin
					off_q   <= off_c;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= {deg_q, rowk_q};
						m_tlast_q  <= (rowk_q == ROW_Z);
						if (deg_q) begin
							m_tdata_q <= '0;
						end else begin
							m_tdata_q <= {2'b00, off_q, rv[2], rv[1], rv[0]};
						end
						idx_q <= '0;
						acc_q <= '0;
						case (rowk_q)
							ROW_X: begin
								rowk_q  <= ROW_Y;
								state_q <= ST_DOT_M;
							end
							ROW_Y: begin
								rowk_q  <= ROW_Z;
								state_q <= ST_DOT_M;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
